// File: design/rpt_pkg.sv
// Shared types and constants for the register producer tracker.
// Used by the top level, the valid table and the testbench; depends on nothing.
`default_nettype none

package rpt_pkg;

    // Field widths of the word on each channel.
    localparam int MODE_W    = 2;
    localparam int SEQ_W     = 64;
    localparam int NSRC_W    = 3;
    localparam int NDST_W    = 2;
    localparam int REG_IDX_W = 9;

    // Number of source and destination fields carried by one word.
    localparam int SRC_FIELDS = 4;
    localparam int DST_FIELDS = 2;
    localparam int DSEL_W     = $clog2(DST_FIELDS);

    // Parameter defaults.
    localparam int NUM_REGS_DEF    = 512;
    localparam int MAX_SOURCES_DEF = 4;
    localparam int MAX_DESTS_DEF   = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_DISPATCH = 2'd0,
        MODE_PEEK     = 2'd1,
        MODE_CLEAR    = 2'd2
    } mode_t;

    // Update request from the lookup stage to the valid table.
    typedef struct packed {
        logic                  clear_all;
        logic [SRC_FIELDS-1:0] stale_clr;
        logic [DST_FIELDS-1:0] set;
    } tbl_ctrl_t;

endpackage

`default_nettype wire

// File: design/register_producer_tracker.sv
// Register producer tracker: an accepted word goes from the input register through
// the single lookup stage to the output register; one word is accepted every cycle
// while the result side does not stall. The lookup stage is fed by one registered
// sequence memory per source lane and destination port.
// Reset clears the valid bits at once, so no clearing pass is needed; the sequence
// memories are not cleared and are read only behind a valid bit.
`default_nettype none

module register_producer_tracker #(
    parameter int NUM_REGS    = rpt_pkg::NUM_REGS_DEF,
    parameter int MAX_SOURCES = rpt_pkg::MAX_SOURCES_DEF,
    parameter int MAX_DESTS   = rpt_pkg::MAX_DESTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [rpt_pkg::MODE_W-1:0]    mode,
    input  wire logic [rpt_pkg::SEQ_W-1:0]     seq_num,
    input  wire logic [rpt_pkg::SEQ_W-1:0]     lowest_valid,
    input  wire logic [rpt_pkg::NSRC_W-1:0]    num_sources,
    input  wire logic [rpt_pkg::REG_IDX_W-1:0] src0,
    input  wire logic [rpt_pkg::REG_IDX_W-1:0] src1,
    input  wire logic [rpt_pkg::REG_IDX_W-1:0] src2,
    input  wire logic [rpt_pkg::REG_IDX_W-1:0] src3,
    input  wire logic [rpt_pkg::NDST_W-1:0]    num_dests,
    input  wire logic [rpt_pkg::REG_IDX_W-1:0] dst0,
    input  wire logic [rpt_pkg::REG_IDX_W-1:0] dst1,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               dep0_valid,
    output logic [rpt_pkg::SEQ_W-1:0]          dep0_seq,
    output logic                               dep1_valid,
    output logic [rpt_pkg::SEQ_W-1:0]          dep1_seq,
    output logic                               dep2_valid,
    output logic [rpt_pkg::SEQ_W-1:0]          dep2_seq,
    output logic                               dep3_valid,
    output logic [rpt_pkg::SEQ_W-1:0]          dep3_seq
);

    import rpt_pkg::*;

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int NLANE = (MAX_SOURCES < SRC_FIELDS) ? MAX_SOURCES : SRC_FIELDS;
    localparam int NDST  = (MAX_DESTS < DST_FIELDS) ? MAX_DESTS : DST_FIELDS;

    logic in_accept;
    logic out_load;

    logic [REG_IDX_W-1:0] src_in     [SRC_FIELDS];
    logic [REG_IDX_W-1:0] dst_in     [DST_FIELDS];
    logic [IDX_W-1:0]     src_in_idx [SRC_FIELDS];

    // Input register.
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [MODE_W-1:0]    s1_mode_reg;
    logic [SEQ_W-1:0]     s1_seq_reg;
    logic [SEQ_W-1:0]     s1_lowest_reg;
    logic [NSRC_W-1:0]    s1_nsrc_reg;
    logic [REG_IDX_W-1:0] s1_src_reg [SRC_FIELDS];
    logic [NDST_W-1:0]    s1_ndst_reg;
    logic [REG_IDX_W-1:0] s1_dst_reg [DST_FIELDS];

    // Writes committed at the edge the word in the input register was read.
    logic [DST_FIELDS-1:0] fwd_en_reg;
    logic [IDX_W-1:0]      fwd_idx_reg [DST_FIELDS];
    logic [SEQ_W-1:0]      fwd_seq_reg;

    logic [SEQ_W-1:0]      ram_rd [SRC_FIELDS][DST_FIELDS];

    tbl_ctrl_t             tbl_ctrl;
    logic [IDX_W-1:0]      src_idx [SRC_FIELDS];
    logic [IDX_W-1:0]      dst_idx [DST_FIELDS];
    logic [SRC_FIELDS-1:0] tbl_rd_valid;
    logic [DSEL_W-1:0]     tbl_rd_last [SRC_FIELDS];

    logic [SRC_FIELDS-1:0] lane_live;
    logic [SRC_FIELDS-1:0] lane_stale;
    logic [SEQ_W-1:0]      lane_seq [SRC_FIELDS];

    // Output register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SRC_FIELDS-1:0] dep_valid_reg;
    logic [SEQ_W-1:0]      dep_seq_reg [SRC_FIELDS];

    assign src_in[0] = src0;
    assign src_in[1] = src1;
    assign src_in[2] = src2;
    assign src_in[3] = src3;
    assign dst_in[0] = dst0;
    assign dst_in[1] = dst1;

    assign out_load  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || out_load;
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_load)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_en_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (in_accept)
            begin
                fwd_en_reg <= tbl_ctrl.set;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg   <= mode;
            s1_seq_reg    <= seq_num;
            s1_lowest_reg <= lowest_valid;
            s1_nsrc_reg   <= num_sources;
            s1_src_reg    <= src_in;
            s1_ndst_reg   <= num_dests;
            s1_dst_reg    <= dst_in;
            fwd_idx_reg   <= dst_idx;
            fwd_seq_reg   <= s1_seq_reg;
        end
    end

    // Sequence memories: every lane keeps its own copy for each destination port.
    genvar gl, gd;
    generate
        for (gl = 0; gl < SRC_FIELDS; gl++)
        begin : g_lane
            assign src_in_idx[gl] = IDX_W'(src_in[gl]);
            for (gd = 0; gd < DST_FIELDS; gd++)
            begin : g_port
                if (gl < NLANE && gd < NDST)
                begin : g_ram
                    rpt_seq_ram #(
                        .DEPTH  (NUM_REGS),
                        .ADDR_W (IDX_W),
                        .DATA_W (SEQ_W)
                    ) u_seq_ram (
                        .clk     (clk),
                        .wr_en   (tbl_ctrl.set[gd]),
                        .wr_addr (dst_idx[gd]),
                        .wr_data (s1_seq_reg),
                        .rd_en   (in_accept),
                        .rd_addr (src_in_idx[gl]),
                        .rd_data (ram_rd[gl][gd])
                    );
                end
                else
                begin : g_none
                    assign ram_rd[gl][gd] = '0;
                end
            end
        end
    endgenerate

    rpt_valid_table #(
        .NUM_REGS (NUM_REGS),
        .IDX_W    (IDX_W)
    ) u_valid_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tbl_ctrl),
        .stale_idx (src_idx),
        .set_idx   (dst_idx),
        .rd_idx    (src_idx),
        .rd_valid  (tbl_rd_valid),
        .rd_last   (tbl_rd_last)
    );

    // Lookup stage. A source that matches a write committed at the same edge as its
    // memory read takes the forwarded number, since the memory returned the old one.
    always_comb
    begin
        logic is_disp;
        logic is_peek;
        logic hit;
        logic in_rng;
        logic req;
        logic found;
        logic older;
        is_disp = (s1_mode_reg == MODE_DISPATCH);
        is_peek = (s1_mode_reg == MODE_PEEK);
        for (int l = 0; l < SRC_FIELDS; l++)
        begin
            src_idx[l] = IDX_W'(s1_src_reg[l]);
            hit = 1'b0;
            for (int d = 0; d < DST_FIELDS; d++)
            begin
                if (fwd_en_reg[d] && fwd_idx_reg[d] == src_idx[l])
                begin
                    hit = 1'b1;
                end
            end
            lane_seq[l] = hit ? fwd_seq_reg : ram_rd[l][tbl_rd_last[l]];
            in_rng = 32'(s1_src_reg[l]) < NUM_REGS;
            if (is_disp)
            begin
                req = (l < NLANE) && (NSRC_W'(l) < s1_nsrc_reg);
            end
            else
            begin
                req = is_peek && (l == 0) && (s1_nsrc_reg != '0);
            end
            found = req && in_rng && tbl_rd_valid[l];
            older = lane_seq[l] < s1_lowest_reg;
            lane_live[l]  = found && !older;
            lane_stale[l] = found && older && is_disp;
        end

        tbl_ctrl.clear_all = out_load && (s1_mode_reg == MODE_CLEAR);
        tbl_ctrl.stale_clr = lane_stale & {SRC_FIELDS{out_load}};
        for (int d = 0; d < DST_FIELDS; d++)
        begin
            dst_idx[d] = IDX_W'(s1_dst_reg[d]);
            tbl_ctrl.set[d] = out_load && is_disp && (d < NDST)
                              && (NDST_W'(d) < s1_ndst_reg)
                              && (32'(s1_dst_reg[d]) < NUM_REGS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            dep_valid_reg <= lane_live;
            for (int l = 0; l < SRC_FIELDS; l++)
            begin
                dep_seq_reg[l] <= lane_live[l] ? lane_seq[l] : '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign dep0_valid = dep_valid_reg[0];
    assign dep0_seq   = dep_seq_reg[0];
    assign dep1_valid = dep_valid_reg[1];
    assign dep1_seq   = dep_seq_reg[1];
    assign dep2_valid = dep_valid_reg[2];
    assign dep2_seq   = dep_seq_reg[2];
    assign dep3_valid = dep_valid_reg[3];
    assign dep3_seq   = dep_seq_reg[3];

endmodule

`default_nettype wire

// File: design/rpt_seq_ram.sv
// One write port, one registered read port memory for producer sequence numbers.
// Depends on nothing; instantiated once per source lane and destination port.
`default_nettype none

module rpt_seq_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9,
    parameter int DATA_W = 64
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read at the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: design/rpt_valid_table.sv
// Per-register valid bits and last-writer port bits of the producer table.
// Depends on rpt_pkg for the update struct and field counts.
`default_nettype none

module rpt_valid_table #(
    parameter int NUM_REGS = 512,
    parameter int IDX_W    = 9
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire rpt_pkg::tbl_ctrl_t       ctrl,
    input  wire logic [IDX_W-1:0]         stale_idx [rpt_pkg::SRC_FIELDS],
    input  wire logic [IDX_W-1:0]         set_idx   [rpt_pkg::DST_FIELDS],
    input  wire logic [IDX_W-1:0]         rd_idx    [rpt_pkg::SRC_FIELDS],
    output logic [rpt_pkg::SRC_FIELDS-1:0] rd_valid,
    output logic [rpt_pkg::DSEL_W-1:0]    rd_last   [rpt_pkg::SRC_FIELDS]
);

    import rpt_pkg::*;

    logic [NUM_REGS-1:0] valid_reg;
    logic [NUM_REGS-1:0] valid_next;
    logic [DSEL_W-1:0]   wport_reg  [NUM_REGS];
    logic [DSEL_W-1:0]   wport_next [NUM_REGS];

    // Stale clears come first, then destination writes; the later port wins.
    always_comb
    begin
        logic              clr;
        logic              hit;
        logic [DSEL_W-1:0] lst;
        for (int e = 0; e < NUM_REGS; e++)
        begin
            clr = ctrl.clear_all;
            hit = 1'b0;
            lst = wport_reg[e];
            for (int l = 0; l < SRC_FIELDS; l++)
            begin
                if (ctrl.stale_clr[l] && stale_idx[l] == IDX_W'(e))
                begin
                    clr = 1'b1;
                end
            end
            for (int d = 0; d < DST_FIELDS; d++)
            begin
                if (ctrl.set[d] && set_idx[d] == IDX_W'(e))
                begin
                    hit = 1'b1;
                    lst = DSEL_W'(d);
                end
            end
            valid_next[e] = hit | (valid_reg[e] & ~clr);
            wport_next[e] = lst;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wport_reg <= wport_next;
    end

    always_comb
    begin
        for (int l = 0; l < SRC_FIELDS; l++)
        begin
            rd_valid[l] = valid_reg[rd_idx[l]];
            rd_last[l]  = wport_reg[rd_idx[l]];
        end
    end

endmodule

`default_nettype wire

// File: design/rpt_checker.sv
// Port-level checks for the register producer tracker, bound to the top level.
// Depends only on the top-level port list.
`default_nettype none

module rpt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        dep0_valid,
    input wire logic [63:0] dep0_seq,
    input wire logic        dep1_valid,
    input wire logic [63:0] dep1_seq,
    input wire logic        dep2_valid,
    input wire logic [63:0] dep2_seq,
    input wire logic        dep3_valid,
    input wire logic [63:0] dep3_seq
);

    // A stalled result word holds; checked on dep0_seq, dep3_seq, dep0_valid and dep1_valid.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(dep0_seq) && $stable(dep3_seq)
            && $stable(dep0_valid) && $stable(dep1_valid))
        else $error("result word changed while stalled");

    // With the output register empty, nothing can hold the input side back.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready while output is empty");

    // A fresh result shows up only after its word was accepted into the input register.
    a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an accepted word");

    // A source with no live producer reports a zero sequence number.
    a_zero_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dep0_valid || dep0_seq == '0) && (dep1_valid || dep1_seq == '0)
            && (dep2_valid || dep2_seq == '0) && (dep3_valid || dep3_seq == '0))
        else $error("nonzero sequence number without a producer");

endmodule

bind register_producer_tracker rpt_checker u_rpt_checker (.*);

`default_nettype wire

// File: dv/register_producer_tracker_check.sv
// Checker for the register producer tracker: predicts every result word from the input
// words it sees accepted and compares each accepted result word field by field.
// Depends on rpt_pkg for widths and mode codes.
`timescale 1ns / 1ps

module register_producer_tracker_check #(
    parameter int NUM_REGS    = rpt_pkg::NUM_REGS_DEF,
    parameter int MAX_SOURCES = rpt_pkg::MAX_SOURCES_DEF,
    parameter int MAX_DESTS   = rpt_pkg::MAX_DESTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [rpt_pkg::MODE_W-1:0]    mode,
    input  logic [rpt_pkg::SEQ_W-1:0]     seq_num,
    input  logic [rpt_pkg::SEQ_W-1:0]     lowest_valid,
    input  logic [rpt_pkg::NSRC_W-1:0]    num_sources,
    input  logic [rpt_pkg::REG_IDX_W-1:0] src0,
    input  logic [rpt_pkg::REG_IDX_W-1:0] src1,
    input  logic [rpt_pkg::REG_IDX_W-1:0] src2,
    input  logic [rpt_pkg::REG_IDX_W-1:0] src3,
    input  logic [rpt_pkg::NDST_W-1:0]    num_dests,
    input  logic [rpt_pkg::REG_IDX_W-1:0] dst0,
    input  logic [rpt_pkg::REG_IDX_W-1:0] dst1,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          dep0_valid,
    input  logic [rpt_pkg::SEQ_W-1:0]     dep0_seq,
    input  logic                          dep1_valid,
    input  logic [rpt_pkg::SEQ_W-1:0]     dep1_seq,
    input  logic                          dep2_valid,
    input  logic [rpt_pkg::SEQ_W-1:0]     dep2_seq,
    input  logic                          dep3_valid,
    input  logic [rpt_pkg::SEQ_W-1:0]     dep3_seq,
    output int                            pending_count,
    output int                            fail_count
);

    import rpt_pkg::*;

    typedef struct packed {
        logic [SRC_FIELDS-1:0]            vld;
        logic [SRC_FIELDS-1:0][SEQ_W-1:0] seq;
    } dep_result_t;

    logic [SEQ_W-1:0] prod_seq   [NUM_REGS];
    logic             prod_valid [NUM_REGS];
    dep_result_t      expected_deps [$];
    int               mismatch_count = 0;

    // Applies one input word to the producer table and returns the dependencies it reports.
    function automatic dep_result_t resolve_dependencies(
        input logic [MODE_W-1:0]                     op,
        input logic [SEQ_W-1:0]                      word_seq,
        input logic [SEQ_W-1:0]                      lowest,
        input logic [NSRC_W-1:0]                     n_src,
        input logic [SRC_FIELDS-1:0][REG_IDX_W-1:0]  srcs,
        input logic [NDST_W-1:0]                     n_dst,
        input logic [DST_FIELDS-1:0][REG_IDX_W-1:0]  dsts
    );
        dep_result_t deps;
        int          live_src;
        int          live_dst;
        int          k;
        deps = '0;
        live_src = n_src;
        if (live_src > MAX_SOURCES)
            live_src = MAX_SOURCES;
        if (live_src > SRC_FIELDS)
            live_src = SRC_FIELDS;
        live_dst = n_dst;
        if (live_dst > MAX_DESTS)
            live_dst = MAX_DESTS;
        if (live_dst > DST_FIELDS)
            live_dst = DST_FIELDS;

        if (op == MODE_DISPATCH)
        begin
            // Sources are looked up in order, so a stale entry cleared by one lane is
            // already invalid for the lanes after it.
            for (k = 0; k < live_src; k++)
            begin
                if (srcs[k] < NUM_REGS && prod_valid[srcs[k]])
                begin
                    if (prod_seq[srcs[k]] < lowest)
                        prod_valid[srcs[k]] = 1'b0;
                    else
                    begin
                        deps.vld[k] = 1'b1;
                        deps.seq[k] = prod_seq[srcs[k]];
                    end
                end
            end
            for (k = 0; k < live_dst; k++)
            begin
                if (dsts[k] < NUM_REGS)
                begin
                    prod_seq[dsts[k]]   = word_seq;
                    prod_valid[dsts[k]] = 1'b1;
                end
            end
        end
        else if (op == MODE_PEEK)
        begin
            if (n_src != 0 && srcs[0] < NUM_REGS && prod_valid[srcs[0]]
                && prod_seq[srcs[0]] >= lowest)
            begin
                deps.vld[0] = 1'b1;
                deps.seq[0] = prod_seq[srcs[0]];
            end
        end
        else if (op == MODE_CLEAR)
        begin
            for (k = 0; k < NUM_REGS; k++)
                prod_valid[k] = 1'b0;
        end
        return deps;
    endfunction

    always @(posedge clk)
    begin : watch
        dep_result_t exp_deps;
        dep_result_t got_deps;
        int          k;
        if (!rst_n)
        begin
            expected_deps.delete();
            for (k = 0; k < NUM_REGS; k++)
            begin
                prod_valid[k] = 1'b0;
                prod_seq[k]   = '0;
            end
        end
        else
        begin
            if (in_valid && in_ready)
                expected_deps.push_back(resolve_dependencies(mode, seq_num, lowest_valid,
                    num_sources, {src3, src2, src1, src0}, num_dests, {dst1, dst0}));
            if (out_valid && out_ready)
            begin
                got_deps.vld = {dep3_valid, dep2_valid, dep1_valid, dep0_valid};
                got_deps.seq = {dep3_seq, dep2_seq, dep1_seq, dep0_seq};
                if (expected_deps.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result word with nothing expected: valid=%b seq0=%h",
                                 $realtime, got_deps.vld, got_deps.seq[0]);
                end
                else
                begin
                    exp_deps = expected_deps.pop_front();
                    for (k = 0; k < SRC_FIELDS; k++)
                    begin
                        if (got_deps.vld[k] !== exp_deps.vld[k]
                            || got_deps.seq[k] !== exp_deps.seq[k])
                        begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display({"%0t: dep%0d expected valid=%b seq=%h,",
                                          " got valid=%b seq=%h"},
                                         $realtime, k, exp_deps.vld[k], exp_deps.seq[k],
                                         got_deps.vld[k], got_deps.seq[k]);
                        end
                    end
                end
            end
        end
        pending_count = expected_deps.size();
        fail_count    = mismatch_count + pending_count;
    end

endmodule

// File: dv/register_producer_tracker_tb.sv
// Top of the register producer tracker testbench: clock, reset, input and result
// handshakes, directed and random words, and the verdict.
// Depends on rpt_pkg, the block, and register_producer_tracker_check.
`timescale 1ns / 1ps

module register_producer_tracker_tb;
    import rpt_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
    localparam logic [SEQ_W-1:0]  SEQ_ALL_ONES   = '1;
    localparam int                RX_HOLD_CYCLES = 300;
    localparam int                HOT_REGS       = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [MODE_W-1:0]    mode;
    logic [SEQ_W-1:0]     seq_num;
    logic [SEQ_W-1:0]     lowest_valid;
    logic [NSRC_W-1:0]    num_sources;
    logic [REG_IDX_W-1:0] src0;
    logic [REG_IDX_W-1:0] src1;
    logic [REG_IDX_W-1:0] src2;
    logic [REG_IDX_W-1:0] src3;
    logic [NDST_W-1:0]    num_dests;
    logic [REG_IDX_W-1:0] dst0;
    logic [REG_IDX_W-1:0] dst1;
    logic                 out_valid;
    logic                 out_ready;
    logic                 dep0_valid;
    logic [SEQ_W-1:0]     dep0_seq;
    logic                 dep1_valid;
    logic [SEQ_W-1:0]     dep1_seq;
    logic                 dep2_valid;
    logic [SEQ_W-1:0]     dep2_seq;
    logic                 dep3_valid;
    logic [SEQ_W-1:0]     dep3_seq;
    int                   pending_count;
    int                   fail_count;

    logic                 steady;
    logic                 rx_hold;
    logic [SEQ_W-1:0]     next_seq;

    register_producer_tracker uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .seq_num      (seq_num),
        .lowest_valid (lowest_valid),
        .num_sources  (num_sources),
        .src0         (src0),
        .src1         (src1),
        .src2         (src2),
        .src3         (src3),
        .num_dests    (num_dests),
        .dst0         (dst0),
        .dst1         (dst1),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dep0_valid   (dep0_valid),
        .dep0_seq     (dep0_seq),
        .dep1_valid   (dep1_valid),
        .dep1_seq     (dep1_seq),
        .dep2_valid   (dep2_valid),
        .dep2_seq     (dep2_seq),
        .dep3_valid   (dep3_valid),
        .dep3_seq     (dep3_seq)
    );

    register_producer_tracker_check dep_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .seq_num       (seq_num),
        .lowest_valid  (lowest_valid),
        .num_sources   (num_sources),
        .src0          (src0),
        .src1          (src1),
        .src2          (src2),
        .src3          (src3),
        .num_dests     (num_dests),
        .dst0          (dst0),
        .dst1          (dst1),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .dep0_valid    (dep0_valid),
        .dep0_seq      (dep0_seq),
        .dep1_valid    (dep1_valid),
        .dep1_seq      (dep1_seq),
        .dep2_valid    (dep2_valid),
        .dep2_seq      (dep2_seq),
        .dep3_valid    (dep3_valid),
        .dep3_seq      (dep3_seq),
        .pending_count (pending_count),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("register_producer_tracker_tb NOT OK");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request so the block backs up.
    initial
    begin : rx_side
        logic held;
        held      = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold && !held)
            begin
                held      = 1'b1;
                out_ready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end
            out_ready = steady || ($urandom_range(99) >= 16);
        end
    end

    // Offers one word and returns once it has been accepted.
    task automatic send_word(
        input logic [MODE_W-1:0]    op,
        input logic [SEQ_W-1:0]     word_seq,
        input logic [SEQ_W-1:0]     lowest,
        input logic [NSRC_W-1:0]    n_src,
        input logic [REG_IDX_W-1:0] s0,
        input logic [REG_IDX_W-1:0] s1,
        input logic [REG_IDX_W-1:0] s2,
        input logic [REG_IDX_W-1:0] s3,
        input logic [NDST_W-1:0]    n_dst,
        input logic [REG_IDX_W-1:0] d0,
        input logic [REG_IDX_W-1:0] d1
    );
        // Each idle cycle is drawn on its own, so about one cycle in six is idle.
        while (!steady && $urandom_range(99) < 16)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid     = 1'b1;
        mode         = op;
        seq_num      = word_seq;
        lowest_valid = lowest;
        num_sources  = n_src;
        src0         = s0;
        src1         = s1;
        src2         = s2;
        src3         = s3;
        num_dests    = n_dst;
        dst0         = d0;
        dst1         = d1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
    endtask

    // Mostly a small set of registers, so that producers are found and go stale.
    function automatic logic [REG_IDX_W-1:0] pick_reg();
        if ($urandom_range(99) < 75)
            return REG_IDX_W'($urandom_range(HOT_REGS - 1));
        return REG_IDX_W'($urandom_range(511));
    endfunction

    function automatic logic [SEQ_W-1:0] trailing_lowest();
        logic [SEQ_W-1:0] lag;
        lag = SEQ_W'($urandom_range(48));
        return (next_seq > lag) ? next_seq - lag : '0;
    endfunction

    function automatic logic [SEQ_W-1:0] rand_seq();
        return {$urandom, $urandom};
    endfunction

    task automatic send_random();
        int               pick;
        logic [SEQ_W-1:0] word_seq;
        logic [NSRC_W-1:0] n_src;
        logic [NDST_W-1:0] n_dst;
        pick = $urandom_range(99);
        if (pick < 3)
            send_word(MODE_W'($urandom_range(3)), rand_seq(), rand_seq(),
                      NSRC_W'($urandom_range(7)), REG_IDX_W'($urandom_range(511)),
                      REG_IDX_W'($urandom_range(511)), REG_IDX_W'($urandom_range(511)),
                      REG_IDX_W'($urandom_range(511)), NDST_W'($urandom_range(3)),
                      REG_IDX_W'($urandom_range(511)), REG_IDX_W'($urandom_range(511)));
        else if (pick < 5)
            send_word(MODE_CLEAR, next_seq, trailing_lowest(), NSRC_W'($urandom_range(7)),
                      pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                      NDST_W'($urandom_range(3)), pick_reg(), pick_reg());
        else if (pick < 7)
            send_word(MODE_UNDEFINED, next_seq, trailing_lowest(), NSRC_W'($urandom_range(7)),
                      pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                      NDST_W'($urandom_range(3)), pick_reg(), pick_reg());
        else if (pick < 22)
        begin
            n_src = ($urandom_range(99) < 10) ? '0 : NSRC_W'($urandom_range(1, 7));
            send_word(MODE_PEEK, next_seq, trailing_lowest(), n_src,
                      pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                      NDST_W'($urandom_range(3)), pick_reg(), pick_reg());
        end
        else
        begin
            word_seq = next_seq;
            next_seq = next_seq + SEQ_W'($urandom_range(1, 2));
            n_src = ($urandom_range(99) < 8) ? NSRC_W'($urandom_range(5, 7))
                                             : NSRC_W'($urandom_range(4));
            n_dst = ($urandom_range(99) < 6) ? NDST_W'(3) : NDST_W'($urandom_range(2));
            send_word(MODE_DISPATCH, word_seq, trailing_lowest(), n_src,
                      pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                      n_dst, pick_reg(), pick_reg());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        mode         = MODE_DISPATCH;
        seq_num      = '0;
        lowest_valid = '0;
        num_sources  = '0;
        src0         = '0;
        src1         = '0;
        src2         = '0;
        src3         = '0;
        num_dests    = '0;
        dst0         = '0;
        dst1         = '0;
        steady       = 1'b0;
        rx_hold      = 1'b0;
        next_seq     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Write every register once, so no later lookup touches a sequence entry
        // that was never written.
        for (int r = 0; r < 512; r += 2)
            send_word(MODE_DISPATCH, rand_seq(), '0, '0, '0, '0, '0, '0, 2'd2,
                      REG_IDX_W'(r), REG_IDX_W'(r + 1));

        // Directed words.
        send_word(MODE_CLEAR, '0, '0, 3'd4, 9'd1, 9'd2, 9'd3, 9'd4, 2'd2, 9'd1, 9'd2);
        send_word(MODE_DISPATCH, 64'd100, '0, 3'd1, 9'd5, 9'd0, 9'd0, 9'd0, 2'd2, 9'd5, 9'd5);
        // The same source four times is reported on every lane.
        send_word(MODE_DISPATCH, 64'd101, 64'd100, 3'd4, 9'd5, 9'd5, 9'd5, 9'd5, 2'd0, 9'd0, 9'd0);
        // A stale producer seen by peek is not cleared.
        send_word(MODE_PEEK, '0, 64'd101, 3'd1, 9'd5, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_PEEK, '0, '0, 3'd1, 9'd5, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        // Dispatch clears it; both lanes find it stale, so neither reports it.
        send_word(MODE_DISPATCH, 64'd102, 64'd101, 3'd2, 9'd5, 9'd5, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_PEEK, '0, '0, 3'd1, 9'd5, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_DISPATCH, SEQ_ALL_ONES, '0, 3'd0, 9'd0, 9'd0, 9'd0, 9'd0, 2'd1,
                  9'd511, 9'd0);
        send_word(MODE_PEEK, '0, SEQ_ALL_ONES, 3'd1, 9'd511, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_PEEK, '0, '0, 3'd0, 9'd511, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_PEEK, '0, '0, 3'd1, 9'd0, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        // Oversized counts are limited to four sources and two destinations.
        send_word(MODE_DISPATCH, '0, '0, 3'd7, 9'd511, 9'd0, 9'd511, 9'd5, 2'd3, 9'd0, 9'd1);
        send_word(MODE_DISPATCH, 64'd200, '0, 3'd4, 9'd0, 9'd1, 9'd1, 9'd0, 2'd2, 9'd1, 9'd0);
        send_word(MODE_UNDEFINED, 64'd300, '0, 3'd4, 9'd0, 9'd1, 9'd511, 9'd5, 2'd2, 9'd5, 9'd5);
        send_word(MODE_PEEK, '0, '0, 3'd4, 9'd5, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_DISPATCH, 64'd12, 64'd12, 3'd3, 9'd1, 9'd0, 9'd511, 9'd0, 2'd2,
                  9'd511, 9'd511);
        send_word(MODE_DISPATCH, 64'd13, 64'd13, 3'd1, 9'd511, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_PEEK, '0, '0, 3'd1, 9'd511, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        send_word(MODE_CLEAR, SEQ_ALL_ONES, SEQ_ALL_ONES, 3'd7, 9'd511, 9'd511, 9'd511, 9'd511,
                  2'd3, 9'd511, 9'd511);
        send_word(MODE_PEEK, '0, '0, 3'd1, 9'd1, 9'd0, 9'd0, 9'd0, 2'd0, 9'd0, 9'd0);
        // A source that is also a destination sees the producer before this word.
        send_word(MODE_DISPATCH, 64'h8000_0000_0000_0000, '0, 3'd1, 9'd256, 9'd0, 9'd0, 9'd0,
                  2'd2, 9'd256, 9'd255);
        send_word(MODE_DISPATCH, 64'd1, 64'h7FFF_FFFF_FFFF_FFFF, 3'd2, 9'd256, 9'd255, 9'd0,
                  9'd0, 2'd0, 9'd0, 9'd0);
        wait_idle();

        // Random words in a mid-range window, with a long hold-off on the result side.
        next_seq = rand_seq() & 64'h7FFF_FFFF_FFFF_FFFF;
        for (int n = 0; n < 600; n++)
        begin
            if (n == 200)
                rx_hold = 1'b1;
            send_random();
        end
        wait_idle();

        steady = 1'b1;
        for (int n = 0; n < 400; n++)
            send_random();
        steady = 1'b0;
        wait_idle();

        // Sequence numbers close to the top of the range.
        next_seq = 64'hFFFF_FFFF_FFFF_E000;
        for (int n = 0; n < 570; n++)
            send_random();
        wait_idle();

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("register_producer_tracker_tb OK");
        else
            $display("register_producer_tracker_tb NOT OK");
        $finish;
    end

endmodule
